>>> rtl/core/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg
// Shared constants and types for the cut-point rank correlation block.
// ----------------------------------------------------------------------------
package crc_pkg;

  localparam int MAX_OBS     = 256;
  localparam int MAX_FACTORS = 8;
  localparam int POS_W       = $clog2(MAX_OBS);
  localparam int FACT_W      = $clog2(MAX_FACTORS);
  localparam int ADDR_W      = FACT_W + POS_W;
  localparam int DEPTH       = MAX_FACTORS * MAX_OBS;
  localparam int RANK_W      = 9;
  localparam int CORR_W      = 18;

  localparam logic [CORR_W-1:0] Q_ONE  = 18'sd65536;
  localparam logic [CORR_W-1:0] Q_ZERO = '0;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_QUERY = 1'b1;

  localparam logic [1:0] REG_OBS_COUNT = 2'd0;
  localparam logic [1:0] REG_MIN_GROUP = 2'd1;
  localparam logic [1:0] REG_MAX_GROUP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUT_RD,
    ST_CUT_GET,
    ST_SCAN,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_MUL5,
    ST_MUL6,
    ST_MUL7,
    ST_DIV,
    ST_SQRT,
    ST_ROUND,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/cutpoint_rank_correlation.sv
// Load: accepted while idle, no result; loads can follow back to back.
// Query (N = effective obs_count): reads the two cut ranks, then scans the first N
//   entries of both lists, two entries a cycle, works the terms on the shared
//   multiplier, divides and takes the root on the shared subtractor, then rounds.
// One item at a time; a new item is taken once the block is back in idle.
// Reset (rst, synchronous): registers to 256/1/255, control idle; store undefined.
// ----------------------------------------------------------------------------
// cutpoint_rank_correlation
// Cut-point rank correlation over stored rank lists, signed Q1.16 result.
// ----------------------------------------------------------------------------
module cutpoint_rank_correlation
  import crc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [FACT_W-1:0]        load_factor,
  input  logic [POS_W-1:0]         load_position,
  input  logic [RANK_W-1:0]        load_rank,
  input  logic [FACT_W-1:0]        row_factor,
  input  logic [POS_W-1:0]         row_position,
  input  logic [FACT_W-1:0]        col_factor,
  input  logic [POS_W-1:0]         col_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CORR_W-1:0] correlation,
  output logic                     row_deleted,
  output logic                     col_deleted,
  output logic                     degenerate
);

  state_t state, state_next;

  logic [RANK_W-1:0] obs_count, min_group, max_group, n;
  logic [FACT_W-1:0] rf, cf;
  logic [POS_W-1:0]  rp, cp, q_d;
  logic [RANK_W-1:0] cnt, m, k, a;
  logic              vld_d, rtie, ctie, neg;
  logic [14:0]       p1, p2;
  logic [16:0]       na, mk, root;
  logic [28:0]       den;
  logic [29:0]       rem;
  logic [33:0]       quo, prod;
  logic [5:0]        iter;
  logic [CORR_W-1:0] corr_r;
  logic              rdel_r, cdel_r, degen_r;

  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [RANK_W-1:0] rd_data_a, rd_data_b;
  logic [16:0]       mul_a, mul_b;
  logic [29:0]       sub_a, sub_b;
  logic [30:0]       diff;
  logic              ge;
  logic [17:0]       num;
  logic [16:0]       mag;
  logic              rdel, cdel, in_fire, cfg_wr;
  logic [16:0]       rnd;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_count <= 9'd256;
      min_group <= 9'd1;
      max_group <= 9'd255;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_OBS_COUNT: obs_count <= pwdata[RANK_W-1:0];
        REG_MIN_GROUP: min_group <= pwdata[RANK_W-1:0];
        REG_MAX_GROUP: max_group <= pwdata[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OBS_COUNT: prdata = {23'd0, obs_count};
      REG_MIN_GROUP: prdata = {23'd0, min_group};
      REG_MAX_GROUP: prdata = {23'd0, max_group};
      default:       prdata = '0;
    endcase
  end

  assign n = (obs_count > 9'(MAX_OBS)) ? 9'(MAX_OBS) : obs_count;

  // ---------------- store ----------------
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = in_fire && (op == OP_LOAD);

  crc_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   ({load_factor, load_position}),
    .wr_data   (load_rank),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // ---------------- shared units ----------------
  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[30];
  assign num  = {1'b0, na} - {1'b0, mk};
  assign mag  = num[17] ? 17'(-num) : num[16:0];
  assign rnd  = 17'((18'({1'b0, root}) + 18'd1) >> 1);

  function automatic logic out_of_range(input logic [RANK_W-1:0] r,
                                        input logic [RANK_W-1:0] nn,
                                        input logic [RANK_W-1:0] lo,
                                        input logic [RANK_W-1:0] hi);
    out_of_range = (r == '0) || (r > nn) || (r < lo) || (r > hi);
  endfunction

  assign rdel = ({1'b0, rp} >= n) || rtie || out_of_range(m, n, min_group, max_group);
  assign cdel = ({1'b0, cp} >= n) || ctie || out_of_range(k, n, min_group, max_group);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_fire && op == OP_QUERY) state_next = ST_CUT_RD;
      ST_CUT_RD:  state_next = ST_CUT_GET;
      ST_CUT_GET: state_next = ST_SCAN;
      ST_SCAN:    if (cnt >= n && !vld_d) state_next = ST_CHECK;
      ST_CHECK:   state_next = (rdel || cdel) ? ST_DONE : ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_MUL3;
      ST_MUL3:    state_next = ST_MUL4;
      ST_MUL4:    state_next = ST_MUL5;
      ST_MUL5:    state_next = ST_MUL6;
      ST_MUL6:    state_next = ST_MUL7;
      ST_MUL7: begin
        if (den == '0 || prod >= 34'(den)) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV:     if (iter == 6'd33) state_next = ST_SQRT;
      ST_SQRT:    if (iter == 6'd16) state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_DONE;
      ST_DONE:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------- unit operand selection ----------------
  always_comb begin
    rd_addr_a = {rf, cnt[POS_W-1:0]};
    rd_addr_b = {cf, cnt[POS_W-1:0]};
    mul_a     = '0;
    mul_b     = '0;
    sub_a     = {rem[28:0], 1'b0};
    sub_b     = 30'(den);
    case (state)
      ST_CUT_RD: begin
        rd_addr_a = {rf, rp};
        rd_addr_b = {cf, cp};
      end
      ST_MUL1: begin mul_a = 17'(m); mul_b = 17'(n - m); end
      ST_MUL2: begin mul_a = 17'(k); mul_b = 17'(n - k); end
      ST_MUL3: begin mul_a = 17'(n); mul_b = 17'(a); end
      ST_MUL4: begin mul_a = 17'(m); mul_b = 17'(k); end
      ST_MUL5: begin mul_a = 17'(p1); mul_b = 17'(p2); end
      ST_MUL6: begin mul_a = mag; mul_b = mag; end
      ST_SQRT: begin
        sub_a = 30'({rem[17:0], quo[33:32]});
        sub_b = 30'({root, 2'b01});
      end
      default: ;
    endcase
  end

  // ---------------- sequencer registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        rf <= row_factor;
        rp <= row_position;
        cf <= col_factor;
        cp <= col_position;
      end
      ST_CUT_GET: begin
        m     <= rd_data_a;
        k     <= rd_data_b;
        cnt   <= '0;
        vld_d <= 1'b0;
        rtie  <= 1'b0;
        ctie  <= 1'b0;
        a     <= '0;
      end
      ST_SCAN: begin
        // compare the pair read last cycle, issue the next one
        if (vld_d) begin
          if (q_d < rp && rd_data_a == m) rtie <= 1'b1;
          if (q_d < cp && rd_data_b == k) ctie <= 1'b1;
          if (rd_data_a <= m && rd_data_b <= k) a <= a + 9'd1;
        end
        if (cnt < n) begin
          q_d   <= cnt[POS_W-1:0];
          cnt   <= cnt + 9'd1;
          vld_d <= 1'b1;
        end else begin
          vld_d <= 1'b0;
        end
      end
      ST_CHECK: begin
        rdel_r  <= rdel;
        cdel_r  <= cdel;
        degen_r <= 1'b0;
        corr_r  <= (rf == cf && rp == cp) ? Q_ONE : Q_ZERO;
      end
      ST_MUL2: p1 <= prod[14:0];
      ST_MUL3: p2 <= prod[14:0];
      ST_MUL4: na <= prod[16:0];
      ST_MUL5: mk <= prod[16:0];
      ST_MUL6: begin
        den <= prod[28:0];
        neg <= num[17];
      end
      ST_MUL7: begin
        rem  <= prod[29:0];
        quo  <= '0;
        iter <= '0;
        if (den == '0) begin
          degen_r <= 1'b1;
          corr_r  <= Q_ZERO;
        end else begin
          corr_r <= neg ? 18'(-Q_ONE) : Q_ONE;
        end
      end
      ST_DIV: begin
        quo <= {quo[32:0], ge};
        if (iter == 6'd33) begin
          rem  <= '0;
          root <= '0;
          iter <= '0;
        end else begin
          rem  <= ge ? diff[29:0] : sub_a;
          iter <= iter + 6'd1;
        end
      end
      ST_SQRT: begin
        rem  <= ge ? 30'(diff[19:0]) : 30'(sub_a[19:0]);
        root <= {root[15:0], ge};
        quo  <= {quo[31:0], 2'b00};
        iter <= iter + 6'd1;
      end
      ST_ROUND: corr_r <= neg ? 18'(-{1'b0, rnd}) : {1'b0, rnd};
      default: ;
    endcase
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      correlation <= corr_r;
      row_deleted <= rdel_r;
      col_deleted <= cdel_r;
      degenerate  <= degen_r;
    end
  end

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> correlation == '0)
    else $error("degenerate result with nonzero correlation");

  a_del_not_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && (row_deleted || col_deleted) |-> !degenerate)
    else $error("deleted cut flagged degenerate");

  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correlation <= 18'sd65536) && (correlation >= -18'sd65536))
    else $error("correlation beyond one");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt <= n)
    else $error("scan counter past list length");
`endif

endmodule

>>> rtl/core/crc_store.sv
// ----------------------------------------------------------------------------
// crc_store
// Rank list store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module crc_store
  import crc_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [RANK_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [RANK_W-1:0] rd_data_a,
  output logic [RANK_W-1:0] rd_data_b
);

  logic [RANK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
